// File: rtl/core/pwfr_pkg.sv
// Shared types and constants of the pulse-width frame receiver.
`default_nettype none
package pwfr_pkg;

	localparam int unsigned TIMER_W   = 17;
	localparam int unsigned PULSE_W   = 15;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT_START = 3'd1,
		PH_MEAS_START = 3'd2,
		PH_WAIT_BIT   = 3'd3,
		PH_MEAS_BIT   = 3'd4
	} phase_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_GARBLED   = 2'd2;
	localparam logic [1:0] ST_WRONG_ADR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIMEOUT   = 3'd4;

	localparam logic [7:0]         RST_OWN_ADDRESS   = 8'd0;
	localparam logic [PULSE_W-1:0] RST_LONG_PULSE    = 15'd400;
	localparam logic [PULSE_W-1:0] RST_SHORT_PULSE   = 15'd200;
	localparam logic [TIMER_W-1:0] RST_START_TIMEOUT = 17'd30000;
	localparam logic [TIMER_W-1:0] RST_BIT_TIMEOUT   = 17'd80000;

	localparam logic [2:0] LAST_BYTE = 3'd4;

endpackage
`default_nettype wire

// File: rtl/core/pulse_width_frame_receiver.sv
// Pulse-width frame receiver: decodes a five-byte frame from line samples.
//
// Feed one line sample per tick on the input channel; an item with arm set
// starts a frame when the receiver is idle. Each item is taken into an input
// register and then runs through the phase, timer and bit decode logic, so the
// block takes one item per clock while the result register is not stalled.
// The result of the item that ends a frame is registered as valid on the output
// channel. A single result register sits on the output; while it is stalled,
// an item in the input register holds there and the input channel stalls. The
// high-time counter saturates at 131071 ticks. Write configuration only while
// no frame is in progress.
`default_nettype none
module pulse_width_frame_receiver (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pwfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pwfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              line_level,
	input  wire logic                              arm,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             status,
	output logic [7:0]                             sender_address,
	output logic [7:0]                             bus_id,
	output logic                                   is_local,
	output logic [7:0]                             data_first,
	output logic [7:0]                             data_second,
	output logic                                   invalid_bits
);

	// configuration
	logic [7:0]                          own_address_q;
	logic [pwfr_pkg::PULSE_W-1:0]        long_pulse_q;
	logic [pwfr_pkg::PULSE_W-1:0]        short_pulse_q;
	logic [pwfr_pkg::TIMER_W-1:0]        start_timeout_q;
	logic [pwfr_pkg::TIMER_W-1:0]        bit_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= pwfr_pkg::RST_OWN_ADDRESS;
			long_pulse_q    <= pwfr_pkg::RST_LONG_PULSE;
			short_pulse_q   <= pwfr_pkg::RST_SHORT_PULSE;
			start_timeout_q <= pwfr_pkg::RST_START_TIMEOUT;
			bit_timeout_q   <= pwfr_pkg::RST_BIT_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwfr_pkg::CFG_OWN_ADDRESS:   own_address_q   <= cfg_data[7:0];
				pwfr_pkg::CFG_LONG_PULSE:    long_pulse_q    <= cfg_data[pwfr_pkg::PULSE_W-1:0];
				pwfr_pkg::CFG_SHORT_PULSE:   short_pulse_q   <= cfg_data[pwfr_pkg::PULSE_W-1:0];
				pwfr_pkg::CFG_START_TIMEOUT: start_timeout_q <= cfg_data;
				pwfr_pkg::CFG_BIT_TIMEOUT:   bit_timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// derived thresholds
	logic [pwfr_pkg::PULSE_W:0]   pulse_sum;
	logic [pwfr_pkg::PULSE_W-1:0] mid;
	logic [pwfr_pkg::PULSE_W:0]   start_min;
	logic [pwfr_pkg::TIMER_W-1:0] mid_ext;
	logic [pwfr_pkg::TIMER_W-1:0] start_min_ext;

	assign pulse_sum     = {1'b0, long_pulse_q} + {1'b0, short_pulse_q};
	assign mid           = pulse_sum[pwfr_pkg::PULSE_W:1];
	assign start_min     = pulse_sum - {2'b00, short_pulse_q[pwfr_pkg::PULSE_W-1:1]};
	assign mid_ext       = {{(pwfr_pkg::TIMER_W-pwfr_pkg::PULSE_W){1'b0}}, mid};
	assign start_min_ext = {{(pwfr_pkg::TIMER_W-pwfr_pkg::PULSE_W-1){1'b0}}, start_min};

	// input register
	logic s1_valid_q;
	logic s1_line_s1;
	logic s1_arm_s1;
	logic advance;
	logic step_en;

	assign advance  = !out_valid || !out_stall;
	assign step_en  = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			s1_line_s1 <= line_level;
			s1_arm_s1  <= arm;
		end
	end

	// receiver state
	pwfr_pkg::phase_t             phase_q, phase_d;
	logic [2:0]                   byte_idx_q, byte_idx_d;
	logic [2:0]                   bit_idx_q, bit_idx_d;
	logic [pwfr_pkg::TIMER_W-1:0] timer_q, timer_d;
	logic [7:0]                   shift_q, shift_d;
	logic                         bad_q, bad_d;
	logic [7:0]                   cap_q [4];
	logic                         cap_we;

	logic [pwfr_pkg::TIMER_W-1:0] timer_inc;
	logic [7:0]                   shift_bit;
	logic                         bit_val, bit_bad;
	logic                         res_fire;
	logic [1:0]                   res_code;

	assign timer_inc = (timer_q == pwfr_pkg::TIMER_MAX) ? timer_q
		: timer_q + pwfr_pkg::TIMER_W'(1);

	// bit decode: zero between mid and start_min, one below mid, else invalid
	always_comb begin
		bit_val = 1'b0;
		bit_bad = 1'b0;
		if (timer_q > mid_ext && timer_q < start_min_ext) begin
			bit_val = 1'b0;
		end else if (timer_q < mid_ext && timer_q < start_min_ext) begin
			bit_val = 1'b1;
		end else begin
			bit_bad = 1'b1;
		end
	end

	assign shift_bit = {shift_q[6:0], bit_val};

	// next state
	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		bit_idx_d  = bit_idx_q;
		timer_d    = timer_q;
		shift_d    = shift_q;
		bad_d      = bad_q;
		cap_we     = 1'b0;
		res_fire   = 1'b0;
		res_code   = pwfr_pkg::ST_OK;
		unique case (phase_q)
			pwfr_pkg::PH_IDLE: begin
				if (s1_arm_s1) begin
					phase_d    = pwfr_pkg::PH_WAIT_START;
					byte_idx_d = '0;
					bit_idx_d  = '0;
					timer_d    = '0;
					shift_d    = '0;
					bad_d      = 1'b0;
				end
			end
			pwfr_pkg::PH_WAIT_START, pwfr_pkg::PH_WAIT_BIT: begin
				if (s1_line_s1) begin
					phase_d = (phase_q == pwfr_pkg::PH_WAIT_START) ? pwfr_pkg::PH_MEAS_START
						: pwfr_pkg::PH_MEAS_BIT;
					timer_d = pwfr_pkg::TIMER_W'(1);
				end else begin
					timer_d = timer_inc;
					if (timer_inc >= ((phase_q == pwfr_pkg::PH_WAIT_START) ? start_timeout_q
						: bit_timeout_q)) begin
						phase_d  = pwfr_pkg::PH_IDLE;
						res_fire = 1'b1;
						res_code = pwfr_pkg::ST_TIMEOUT;
					end
				end
			end
			pwfr_pkg::PH_MEAS_START: begin
				if (s1_line_s1) begin
					timer_d = timer_inc;
				end else if (timer_q <= start_min_ext) begin
					phase_d  = pwfr_pkg::PH_IDLE;
					res_fire = 1'b1;
					res_code = pwfr_pkg::ST_GARBLED;
				end else begin
					bit_idx_d = '0;
					shift_d   = '0;
					phase_d   = pwfr_pkg::PH_WAIT_BIT;
					timer_d   = pwfr_pkg::TIMER_W'(1);
					if (bit_timeout_q <= pwfr_pkg::TIMER_W'(1)) begin
						phase_d  = pwfr_pkg::PH_IDLE;
						res_fire = 1'b1;
						res_code = pwfr_pkg::ST_TIMEOUT;
					end
				end
			end
			pwfr_pkg::PH_MEAS_BIT: begin
				if (s1_line_s1) begin
					timer_d = timer_inc;
				end else begin
					shift_d   = shift_bit;
					bad_d     = bad_q | bit_bad;
					bit_idx_d = bit_idx_q + 3'd1;
					if (bit_idx_q != 3'd7) begin
						phase_d = pwfr_pkg::PH_WAIT_BIT;
						timer_d = pwfr_pkg::TIMER_W'(1);
						if (bit_timeout_q <= pwfr_pkg::TIMER_W'(1)) begin
							phase_d  = pwfr_pkg::PH_IDLE;
							res_fire = 1'b1;
							res_code = pwfr_pkg::ST_TIMEOUT;
						end
					end else if (byte_idx_q >= pwfr_pkg::LAST_BYTE) begin
						// frame complete
						phase_d  = pwfr_pkg::PH_IDLE;
						res_fire = 1'b1;
						res_code = (cap_q[0] != own_address_q) ? pwfr_pkg::ST_WRONG_ADR
							: pwfr_pkg::ST_OK;
					end else begin
						cap_we     = 1'b1;
						byte_idx_d = byte_idx_q + 3'd1;
						phase_d    = pwfr_pkg::PH_WAIT_START;
						timer_d    = pwfr_pkg::TIMER_W'(1);
						if (start_timeout_q <= pwfr_pkg::TIMER_W'(1)) begin
							phase_d  = pwfr_pkg::PH_IDLE;
							res_fire = 1'b1;
							res_code = pwfr_pkg::ST_TIMEOUT;
						end
					end
				end
			end
			default: begin
				phase_d = pwfr_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= pwfr_pkg::PH_IDLE;
			byte_idx_q <= '0;
			bit_idx_q  <= '0;
			timer_q    <= '0;
			shift_q    <= '0;
			bad_q      <= 1'b0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			bit_idx_q  <= bit_idx_d;
			timer_q    <= timer_d;
			shift_q    <= shift_d;
			bad_q      <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cap_we) begin
			cap_q[byte_idx_q[1:0]] <= shift_bit;
		end
	end

	// result fields: everything but status is zero on an error
	logic       res_ok;
	logic [7:0] res_sender, res_bus, res_d1, res_d2;
	logic       res_local, res_bad;

	always_comb begin
		res_ok     = (res_code == pwfr_pkg::ST_OK);
		res_sender = res_ok ? cap_q[1] : 8'd0;
		res_bus    = res_ok ? cap_q[2] : 8'd0;
		res_local  = res_ok && (cap_q[2] == 8'd0);
		res_d1     = res_ok ? cap_q[3] : 8'd0;
		res_d2     = res_ok ? shift_bit : 8'd0;
		res_bad    = res_ok && (bad_q | bit_bad);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step_en && res_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_fire) begin
			status         <= res_code;
			sender_address <= res_sender;
			bus_id         <= res_bus;
			is_local       <= res_local;
			data_first     <= res_d1;
			data_second    <= res_d2;
			invalid_bits   <= res_bad;
		end
	end

endmodule
`default_nettype wire
